// ===== hw/rtl/snll_pkg.sv =====
// Shared types and constants for the stereo nonlinear ladder lowpass.
// Holds the sequencer state encoding, register indexes and reset values.
// No dependencies.
`default_nettype none

package snll_pkg;

  // Coefficient registers are unsigned Q4.20
  localparam int unsigned COEF_W    = 24;
  localparam int unsigned COEF_FRAC = 20;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_VT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRY       = 3'd5;

  // Register reset values
  localparam logic [COEF_W-1:0] DRIVE_RST     = 24'd1048576;
  localparam logic [COEF_W-1:0] RESONANCE_RST = 24'd0;
  localparam logic [COEF_W-1:0] STEP_RST      = 24'd78294;
  localparam logic [COEF_W-1:0] INV_VT_RST    = 24'd1680410;
  localparam logic [COEF_W-1:0] WET_RST       = 24'd4194304;
  localparam logic [COEF_W-1:0] DRY_RST       = 24'd0;

  // Sequencer states, one-hot
  typedef enum logic [17:0] {
    ST_IDLE  = 18'h00001,
    ST_DRV   = 18'h00002,
    ST_RES   = 18'h00004,
    ST_ARG   = 18'h00008,
    ST_ARGM  = 18'h00010,
    ST_XSAT  = 18'h00020,
    ST_TSQ   = 18'h00040,
    ST_TNUM  = 18'h00080,
    ST_TDIV0 = 18'h00100,
    ST_TDIV  = 18'h00200,
    ST_TEND  = 18'h00400,
    ST_SPREP = 18'h00800,
    ST_SMUL  = 18'h01000,
    ST_SVOL  = 18'h02000,
    ST_SVMUL = 18'h04000,
    ST_WET   = 18'h08000,
    ST_DRYM  = 18'h10000,
    ST_MIX   = 18'h20000
  } seq_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/stereo_nonlinear_ladder_lowpass.sv =====
// Stereo four-pole nonlinear ladder lowpass, top level.
// Depends on snll_pkg for state encoding, register indexes and reset values.
//
// Each item is one sample per channel (signed Q4.20 at the default width) and
// yields one filtered, mixed and saturated sample per channel. All products
// and quotients run through one shared multiplier and one restoring divider
// under a sequencer; the block takes one item at a time and in_ready_o is
// high only while it is idle. The tanh approximation divides one quotient bit
// per cycle; a tanh argument at or beyond +-3 skips its division. A finished
// result sits in the output register until taken; the last channel waits in
// its mix step only if the previous result is still pending. Coefficients are
// written through the cfg port with no read-back; the user must write them
// only while idle, as the block itself does not enforce it.
`default_nettype none

module stereo_nonlinear_ladder_lowpass #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned CHANNELS     = 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [snll_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [snll_pkg::COEF_W-1:0]         cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      left_in_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      right_in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]           left_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]           right_out_o
);
  import snll_pkg::*;

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned FRAC = SW - 4;
  localparam int unsigned BW   = (SW + 3 > COEF_W + 1) ? SW + 3 : COEF_W + 1;
  localparam int unsigned PW   = SW + BW;
  localparam int unsigned AW   = PW + 1;
  localparam int unsigned QB   = FRAC + 1;
  localparam int unsigned DW   = FRAC + 7;
  localparam int unsigned RW   = 2 * FRAC + 7;
  localparam int unsigned X2W  = FRAC + 4;
  localparam int unsigned CNTW = $clog2(QB);
  localparam int unsigned NST  = CHANNELS * 4;
  localparam int unsigned IW   = $clog2(NST);

  localparam logic signed [AW-1:0] DMAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] DMIN = ~DMAX;
  localparam logic signed [SW-1:0] THREE = SW'(3) <<< FRAC;
  localparam logic [SW+1:0]        K27  = (SW+2)'(27) << FRAC;
  localparam logic [QB-1:0]        Q_ONE = QB'(1) << FRAC;
  localparam logic [CNTW-1:0]      CNT_LAST = CNTW'(QB - 1);

  function automatic logic signed [SW-1:0] sat(input logic signed [AW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > DMAX) r = DMAX[SW-1:0];
    else if (v < DMIN) r = DMIN[SW-1:0];
    else r = v[SW-1:0];
    return r;
  endfunction

  seq_state_e state_q, state_d;

  // Coefficient registers
  logic [COEF_W-1:0] drive_q, res_q, step_q, inv_q, wet_q, dry_q;

  // Stage state per channel and stage
  logic signed [SW-1:0] volt_q  [NST];
  logic signed [SW-1:0] slope_q [NST];
  logic signed [SW-1:0] tanh_q  [NST];

  // Datapath registers
  logic signed [SW-1:0] in0_q, in1_q, x_q, drv_q, tq_q, lres_q;
  logic signed [AW-1:0] acc_q;
  logic signed [PW-1:0] p_q;
  logic [DW-1:0]        den_q;
  logic [RW-1:0]        rem_q, dsr_q;
  logic [QB-1:0]        q_q;
  logic                 neg_q;
  logic [CNTW-1:0]      cnt_q;
  logic                 ch_q, phase_arg_q;
  logic [1:0]           k_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_l_q, out_r_q;

  // Combinational helpers
  logic [1:0]           sel_k;
  logic [IW-1:0]        idx;
  logic signed [SW-1:0] in_sel, v_rd, s_rd, t_rd;
  logic signed [SW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [AW-1:0] p_shift;
  logic signed [SW-1:0] p_sat;
  logic [X2W-1:0]       x2;
  logic signed [PW-1:0] p_neg;
  logic                 div_ge;
  logic signed [SW-1:0] tval;
  logic signed [SW:0]   drv_sum;
  logic signed [SW-1:0] s_new, v_new;
  logic signed [SW-1:0] mix_val;
  logic                 last_ch, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  // Select entry: the last stage while forming feedback, else the current stage
  always_comb begin
    sel_k = k_q;
    if (state_q == ST_DRV || state_q == ST_RES) sel_k = 2'd3;
  end
  assign idx    = IW'({ch_q, sel_k});
  assign in_sel = ch_q ? in1_q : in0_q;
  assign v_rd   = volt_q[idx];
  assign s_rd   = slope_q[idx];
  assign t_rd   = tanh_q[idx];

  // Product scaling and saturation
  assign p_shift = AW'(p_q >>> COEF_FRAC);
  assign p_sat   = sat(p_shift);
  assign x2      = p_q[FRAC +: X2W];
  assign p_neg   = -p_q;
  assign div_ge  = (rem_q >= dsr_q);
  assign tval    = neg_q ? -SW'(q_q) : SW'(q_q);
  assign drv_sum = (k_q == 2'd0) ? -((SW+1)'(tq_q) + (SW+1)'(t_rd))
                                 : (SW+1)'(tq_q) - (SW+1)'(t_rd);
  assign s_new   = p_sat;
  assign v_new   = sat(AW'(v_rd) + AW'(s_new) + AW'(s_rd));
  assign mix_val = sat(acc_q + p_shift);
  assign last_ch = (ch_q == 1'(CHANNELS - 1));
  assign out_free = !out_valid_q || out_ready_i;

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DRV:   begin mul_a = in_sel; mul_b = BW'(drive_q); end
      ST_RES:   begin mul_a = v_rd;   mul_b = BW'(res_q);   end
      ST_ARGM:  begin mul_a = x_q;    mul_b = BW'(inv_q);   end
      ST_TSQ:   begin mul_a = x_q;    mul_b = BW'(x_q);     end
      ST_TNUM:  begin mul_a = x_q;    mul_b = BW'(K27 + (SW+2)'(x2)); end
      ST_SMUL:  begin mul_a = drv_q;  mul_b = BW'(step_q);  end
      ST_SVMUL: begin mul_a = v_rd;   mul_b = BW'(inv_q);   end
      ST_WET:   begin mul_a = v_rd;   mul_b = BW'(wet_q);   end
      ST_DRYM:  begin mul_a = in_sel; mul_b = BW'(dry_q);   end
      default:  begin mul_a = '0;     mul_b = '0;           end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_DRV;
      ST_DRV:   state_d = ST_RES;
      ST_RES:   state_d = ST_ARG;
      ST_ARG:   state_d = ST_ARGM;
      ST_ARGM:  state_d = ST_XSAT;
      ST_XSAT:  state_d = ST_TSQ;
      ST_TSQ:   state_d = (x_q >= THREE || x_q <= -THREE) ? ST_TEND : ST_TNUM;
      ST_TNUM:  state_d = ST_TDIV0;
      ST_TDIV0: state_d = ST_TDIV;
      ST_TDIV:  if (cnt_q == '0) state_d = ST_TEND;
      ST_TEND:  state_d = (!phase_arg_q && k_q == 2'd3) ? ST_WET : ST_SPREP;
      ST_SPREP: state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_SVOL;
      ST_SVOL:  state_d = ST_SVMUL;
      ST_SVMUL: state_d = ST_XSAT;
      ST_WET:   state_d = ST_DRYM;
      ST_DRYM:  state_d = ST_MIX;
      ST_MIX: begin
        if (!last_ch) state_d = ST_DRV;
        else if (out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control and stage state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drive_q     <= DRIVE_RST;
      res_q       <= RESONANCE_RST;
      step_q      <= STEP_RST;
      inv_q       <= INV_VT_RST;
      wet_q       <= WET_RST;
      dry_q       <= DRY_RST;
      ch_q        <= 1'b0;
      k_q         <= 2'd0;
      phase_arg_q <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NST; i++) begin
        volt_q[i]  <= '0;
        slope_q[i] <= '0;
        tanh_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;

      // Write coefficients; unknown indexes drop
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_DRIVE:     drive_q <= cfg_data_i;
          REG_RESONANCE: res_q   <= cfg_data_i;
          REG_STEP:      step_q  <= cfg_data_i;
          REG_INV_VT:    inv_q   <= cfg_data_i;
          REG_WET:       wet_q   <= cfg_data_i;
          REG_DRY:       dry_q   <= cfg_data_i;
          default:       ;
        endcase
      end

      // Raise valid when the last channel finishes, drop it once taken
      if (state_q == ST_MIX && last_ch && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            ch_q        <= 1'b0;
            phase_arg_q <= 1'b1;
          end
        end
        ST_TDIV: cnt_q <= cnt_q - CNTW'(1);
        ST_TDIV0: cnt_q <= CNT_LAST;
        ST_TEND: begin
          if (phase_arg_q) begin
            phase_arg_q <= 1'b0;
            k_q         <= 2'd0;
          end else begin
            tanh_q[idx] <= tval;
            if (k_q != 2'd3) k_q <= k_q + 2'd1;
          end
        end
        ST_SVOL: begin
          volt_q[idx]  <= v_new;
          slope_q[idx] <= s_new;
        end
        ST_MIX: begin
          if (!last_ch) begin
            ch_q        <= 1'b1;
            phase_arg_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in0_q <= left_in_i;
          in1_q <= right_in_i;
        end
      end
      ST_RES:  acc_q <= p_shift;
      ST_ARG:  x_q <= sat(acc_q + p_shift);
      ST_XSAT: x_q <= p_sat;
      ST_TSQ: begin
        q_q   <= Q_ONE;
        neg_q <= x_q[SW-1];
      end
      ST_TNUM: den_q <= DW'(K27) + (DW'(x2) << 3) + DW'(x2);
      ST_TDIV0: begin
        neg_q <= p_q[PW-1];
        rem_q <= p_q[PW-1] ? p_neg[RW-1:0] : p_q[RW-1:0];
        dsr_q <= RW'(den_q) << (QB - 1);
        q_q   <= '0;
      end
      ST_TDIV: begin
        if (div_ge) rem_q <= rem_q - dsr_q;
        q_q   <= {q_q[QB-2:0], div_ge};
        dsr_q <= dsr_q >> 1;
      end
      ST_TEND:  tq_q <= tval;
      ST_SPREP: drv_q <= drv_sum[SW-1:0];
      ST_DRYM:  acc_q <= p_shift;
      ST_MIX: begin
        if (!last_ch) begin
          lres_q <= mix_val;
        end else if (out_free) begin
          out_l_q <= (CHANNELS > 1) ? lres_q : mix_val;
          out_r_q <= (CHANNELS > 1) ? mix_val : '0;
        end else begin
          // Hold the mixed value while the previous result is pending
          acc_q <= AW'(mix_val);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the stereo nonlinear ladder lowpass.
// Drives random and directed stereo pairs, predicts each filtered pair, checks outputs.
// Depends on snll_pkg and stereo_nonlinear_ladder_lowpass.
`timescale 1ns / 100ps

module tb_top;
  import snll_pkg::*;

  localparam int SW = 24;
  localparam int FRACB = 20;
  localparam longint DMAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint DMIN = -DMAX - 1;
  localparam longint LIMIT = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COEF_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SW-1:0] left_in_i = '0;
  logic signed [SW-1:0] right_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [SW-1:0] left_out_o;
  logic signed [SW-1:0] right_out_o;

  stereo_nonlinear_ladder_lowpass uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .left_in_i(left_in_i), .right_in_i(right_in_i), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i), .left_out_o(left_out_o), .right_out_o(right_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state and coefficients
  longint coef [6];
  longint volt [8];
  longint slope [8];
  longint tanhv [8];
  logic [2*SW-1:0] pair_q [$];
  int mismatches = 0;
  longint cycles = 0;
  int hold_off = 0;
  bit long_hold = 0;

  function automatic longint clamp(longint v);
    if (v > DMAX) return DMAX;
    if (v < DMIN) return DMIN;
    return v;
  endfunction

  // Floor shift is an arithmetic shift right on two's complement
  function automatic longint scale(longint d, longint c);
    return (d * c) >>> FRACB;
  endfunction

  function automatic longint soft_tanh(longint x);
    longint one, x2, num, den;
    one = 64'sd1 <<< FRACB;
    if (x >= 3 * one) return one;
    if (x <= -3 * one) return -one;
    x2 = (x * x) >>> FRACB;
    num = x * (27 * one + x2);
    den = 27 * one + 9 * x2;
    return num / den;
  endfunction

  function automatic longint ladder_channel(int ch, longint smp);
    int b, i;
    longint arg, drv, s;
    b = ch * 4;
    arg = clamp(scale(smp, coef[REG_DRIVE]) + scale(volt[b+3], coef[REG_RESONANCE]));
    arg = clamp(scale(arg, coef[REG_INV_VT]));
    drv = -(soft_tanh(arg) + tanhv[b]);
    for (int k = 0; k < 4; k++) begin
      i = b + k;
      if (k > 0) drv = tanhv[i-1] - tanhv[i];
      s = clamp(scale(drv, coef[REG_STEP]));
      volt[i] = clamp(volt[i] + s + slope[i]);
      slope[i] = s;
      tanhv[i] = soft_tanh(clamp(scale(volt[i], coef[REG_INV_VT])));
    end
    return clamp(scale(volt[b+3], coef[REG_WET]) + scale(smp, coef[REG_DRY]));
  endfunction

  function automatic void predict_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    logic signed [SW-1:0] lo, ro;
    lo = SW'(ladder_channel(0, longint'(l)));
    ro = SW'(ladder_channel(1, longint'(r)));
    pair_q.push_back({lo, ro});
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(posedge clk_i) begin
    if (long_hold && hold_off == 0) begin
      hold_off <= 3000;
      long_hold <= 0;
      out_ready_i <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (out_ready_i && out_valid_o) begin
      out_ready_i <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
      hold_off <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    logic [2*SW-1:0] exp_pair;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pair_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d", left_out_o, right_out_o);
      end else begin
        exp_pair = pair_q.pop_front();
        if (exp_pair != {left_out_o, right_out_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp L=%0d R=%0d got L=%0d R=%0d",
                     $signed(exp_pair[2*SW-1:SW]), $signed(exp_pair[SW-1:0]),
                     left_out_o, right_out_o);
        end
      end
    end
  end

  // Offer one item; valid stays up after acceptance until the next gap or drain
  task automatic send_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14)) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_in_i <= l;
    right_in_i <= r;
    predict_pair(l, r);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    if (idx <= REG_DRY) coef[idx] = longint'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for all results, then a latency margin before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pair_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return SW'(DMAX);
      1: return SW'(DMIN);
      2: return SW'($signed($urandom_range(0, 2097151)) - 1048576);
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(SW'(0), SW'(0), 0);
    send_pair(SW'(DMAX), SW'(DMIN), 0);
    send_pair(SW'(DMIN), SW'(DMAX), 1);
    send_pair(SW'(1 <<< FRACB), -SW'(1 <<< FRACB), 1);
    send_pair(SW'(-1), SW'(1), 1);
    send_pair(SW'(3 <<< FRACB), SW'(-(3 <<< FRACB)), 1);
    send_pair(SW'(DMAX), SW'(DMAX), 0);
    send_pair(SW'(DMIN), SW'(DMIN), 0);
    drain();
    // Extreme registers: everything maxed drives saturation, and unused indexes are written too
    write_reg(REG_DRIVE, '1);
    write_reg(REG_RESONANCE, '1);
    write_reg(REG_STEP, '1);
    write_reg(REG_INV_VT, '1);
    write_reg(REG_WET, '1);
    write_reg(REG_DRY, '1);
    write_reg(3'd6, 24'h123456);
    write_reg(3'd7, '1);
    for (int i = 0; i < 6; i++) send_pair(i[0] ? SW'(DMAX) : SW'(DMIN), SW'(i * 777), 1);
    drain();
    // All zero coefficients
    for (int i = 0; i <= REG_DRY; i++) write_reg(CFG_IDX_W'(i), '0);
    for (int i = 0; i < 4; i++) send_pair(rand_sample(), rand_sample(), 1);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_pair(rand_sample(), rand_sample(), $urandom_range(0, 4) != 0);
  endtask

  task automatic test_settings();
    // Musical settings with varied resonance up to self oscillation, then fully random registers
    write_reg(REG_DRIVE, 24'(DRIVE_RST + $urandom_range(0, 4194304)));
    write_reg(REG_RESONANCE, 24'($urandom_range(0, 4194304)));
    write_reg(REG_STEP, 24'($urandom_range(1000, 600000)));
    write_reg(REG_INV_VT, INV_VT_RST);
    write_reg(REG_WET, WET_RST);
    write_reg(REG_DRY, 24'($urandom_range(0, 1048576)));
    test_random(200);
    drain();
    for (int i = 0; i <= REG_DRY; i++) write_reg(CFG_IDX_W'(i), 24'($urandom));
    test_random(150);
    drain();
  endtask

  task automatic test_backpressure();
    long_hold = 1;
    test_random(20);
    test_random(180);
  endtask

  initial begin
    coef[0] = DRIVE_RST; coef[1] = RESONANCE_RST; coef[2] = STEP_RST;
    coef[3] = INV_VT_RST; coef[4] = WET_RST; coef[5] = DRY_RST;
    for (int i = 0; i < 8; i++) begin
      volt[i] = 0; slope[i] = 0; tanhv[i] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_random(280);
    drain();
    test_directed();
    test_settings();
    test_backpressure();
    drain();
    if (mismatches == 0 && pair_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
